>>> rtl/adf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adf_pkg: shared types and constants for the HDLC deframer
// Byte codes, CRC-16/X.25 constants and update, frame status codes and the
// result record passed from the decode core to the output register.
// ----------------------------------------------------------------------------
package adf_pkg;

  // framing bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // CRC-16/X.25, reflected form
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_GOOD   = 16'hF0B8;

  // field widths
  localparam int unsigned LEN_W = 13;

  // number of FCS bytes held back at the tail of a frame
  localparam logic [LEN_W-1:0] FCS_BYTES = LEN_W'(2);

  // size limit after reset
  localparam logic [LEN_W-1:0] CFG_RESET = LEN_W'(4096);

  typedef enum logic [2:0] {
    ST_GOOD  = 3'd0,
    ST_CRC   = 3'd1,
    ST_RUNT  = 3'd2,
    ST_ABORT = 3'd3,
    ST_BIG   = 3'd4
  } status_e;

  typedef struct packed {
    logic             data_valid;
    logic [7:0]       payload;
    logic             frame_end;
    status_e          status;
    logic [LEN_W-1:0] length;
  } result_t;

  // one byte through the reflected CRC, LSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

>>> rtl/async_hdlc_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// async_hdlc_deframer: asynchronous HDLC receive deframer with CRC-16/X.25
// Input register, byte decode with CRC, registered result stream.
// ----------------------------------------------------------------------------
// Path: input register, then byte decode, then result register. Throughput:
// one byte per cycle unless m_axis_tready stalls the result register, set by
// the byte-wide CRC update and count/limit compare between those registers.
// Reset (asynchronous, active low): escape, hunt and frame state cleared,
// CRC preset, size limit to 4096 (capped at MAX_FRAME), both stages empty.
module async_hdlc_deframer #(
  parameter int unsigned MAX_FRAME = 4096
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  // configuration: max_frame_size
  input  wire                       cfg_we_i,
  input  wire  [adf_pkg::LEN_W-1:0] cfg_wdata_i,
  // received bytes
  input  wire                       s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire  [7:0]                s_axis_tdata,   // [7:0] rx_byte
  // decoded stream
  output logic                      m_axis_tvalid,
  input  wire                       m_axis_tready,
  output logic [23:0]               m_axis_tdata,   // [7:0] payload_byte,
                                                    // [10:8] frame_status,
                                                    // [23:11] frame_length
  output logic                      m_axis_tlast,   // frame_end
  output logic                      m_axis_tuser    // data_valid
);
  import adf_pkg::*;

  localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
  localparam int unsigned LIM_CAP = (MAX_FRAME > LEN_MAX) ? LEN_MAX : MAX_FRAME;
  localparam int unsigned CNT_W   = $clog2(LIM_CAP + 1);
  localparam logic [LEN_W-1:0] LIM_CAP_V = LEN_W'(LIM_CAP);

  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_byte_q;
  logic             in_adv;
  logic [LEN_W-1:0] limit_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_q;
  logic             res_valid;
  result_t          res;

  // size limit, capped on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= (CFG_RESET > LIM_CAP_V) ? LIM_CAP_V : CFG_RESET;
    end else if (cfg_we_i) begin
      limit_q <= (cfg_wdata_i > LIM_CAP_V) ? LIM_CAP_V : cfg_wdata_i;
    end
  end

  // input stage handshake
  assign in_adv        = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || in_adv;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // decode core
  adf_core #(
    .CNT_W (CNT_W)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (in_adv),
    .byte_i      (in_byte_q),
    .limit_i     (limit_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  assign out_valid_d = in_adv ? res_valid : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.length, 3'(out_q.status), out_q.payload};
  assign m_axis_tlast  = out_q.frame_end;
  assign m_axis_tuser  = out_q.data_valid;

endmodule
`default_nettype wire

>>> rtl/adf_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adf_core: frame decode state and CRC
// Holds escape, hunt, open-frame, CRC, byte count and the two-byte hold-back.
// Each request advanced updates state in one step and may give one result.
// ----------------------------------------------------------------------------
module adf_core #(
  parameter int unsigned CNT_W = 13
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          adv_i,
  input  wire  [7:0]                   byte_i,
  input  wire  [adf_pkg::LEN_W-1:0]    limit_i,
  output logic                         res_valid_o,
  output adf_pkg::result_t             res_o
);
  import adf_pkg::*;

  logic             esc_q, esc_d;
  logic             hunt_q, hunt_d;
  logic             open_q, open_d;
  logic [15:0]      crc_q, crc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       held_cnt_q, held_cnt_d;
  logic [7:0]       held0_q, held0_d;
  logic [7:0]       held1_q, held1_d;

  logic [7:0]       chr;
  logic [LEN_W-1:0] cnt_ext;

  assign chr     = esc_q ? (byte_i ^ ESC_XOR) : byte_i;
  assign cnt_ext = LEN_W'(cnt_q);

  // next state and result
  always_comb begin
    esc_d       = esc_q;
    hunt_d      = hunt_q;
    open_d      = open_q;
    crc_d       = crc_q;
    cnt_d       = cnt_q;
    held_cnt_d  = held_cnt_q;
    held0_d     = held0_q;
    held1_d     = held1_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (adv_i) begin
      priority if (byte_i == ESC_BYTE) begin
        esc_d = 1'b1;
      end else if (byte_i != FLAG_BYTE) begin
        // data byte, ignored while hunting
        if (!hunt_q) begin
          esc_d  = 1'b0;
          open_d = 1'b1;
          if (cnt_ext >= limit_i) begin
            res_valid_o     = 1'b1;
            res_o.frame_end = 1'b1;
            res_o.status    = ST_BIG;
            res_o.length    = cnt_ext;
            open_d          = 1'b0;
            crc_d           = CRC_PRESET;
            cnt_d           = '0;
            held_cnt_d      = '0;
            hunt_d          = 1'b1;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
            crc_d = crc_update(crc_q, chr);
            if (held_cnt_q == 2'd2) begin
              res_valid_o      = 1'b1;
              res_o.data_valid = 1'b1;
              res_o.payload    = held0_q;
              held0_d          = held1_q;
              held1_d          = chr;
            end else begin
              if (held_cnt_q == 2'd0) begin
                held0_d = chr;
              end else begin
                held1_d = chr;
              end
              held_cnt_d = held_cnt_q + 2'd1;
            end
          end
        end
      end else if (esc_q) begin
        // escape then flag: abort
        esc_d      = 1'b0;
        hunt_d     = 1'b1;
        open_d     = 1'b0;
        crc_d      = CRC_PRESET;
        cnt_d      = '0;
        held_cnt_d = '0;
        if (open_q) begin
          res_valid_o     = 1'b1;
          res_o.frame_end = 1'b1;
          res_o.status    = ST_ABORT;
          res_o.length    = cnt_ext;
        end
      end else if (hunt_q) begin
        hunt_d = 1'b0;
      end else if (open_q) begin
        // closing flag
        open_d          = 1'b0;
        crc_d           = CRC_PRESET;
        cnt_d           = '0;
        held_cnt_d      = '0;
        res_valid_o     = 1'b1;
        res_o.frame_end = 1'b1;
        priority if (crc_q != CRC_GOOD) begin
          res_o.status = ST_CRC;
          res_o.length = cnt_ext;
        end else if (cnt_ext < FCS_BYTES) begin
          res_o.status = ST_RUNT;
          res_o.length = cnt_ext;
        end else begin
          res_o.status = ST_GOOD;
          res_o.length = cnt_ext - FCS_BYTES;
        end
      end else begin
        // padding flag between frames: no change
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q      <= 1'b0;
      hunt_q     <= 1'b0;
      open_q     <= 1'b0;
      crc_q      <= CRC_PRESET;
      cnt_q      <= '0;
      held_cnt_q <= '0;
    end else begin
      esc_q      <= esc_d;
      hunt_q     <= hunt_d;
      open_q     <= open_d;
      crc_q      <= crc_d;
      cnt_q      <= cnt_d;
      held_cnt_q <= held_cnt_d;
    end
  end

  // held-back bytes, read only once two are held
  always_ff @(posedge clk_i) begin
    held0_q <= held0_d;
    held1_q <= held1_d;
  end

`ifndef ASSERT_OFF
  a_hunt_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hunt_q |-> !open_q)
    else $error("hunt mode with a frame open");

  a_data_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.data_valid) |-> (held_cnt_q == 2'd2 && open_q))
    else $error("payload byte without two bytes held");

  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.frame_end) |=> (!open_q && cnt_q == '0 && crc_q == CRC_PRESET))
    else $error("frame state not cleared after frame end");

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_cnt_q != 2'd3) && ((held_cnt_q == 2'd0) || open_q))
    else $error("hold-back count out of range");
`endif

endmodule
`default_nettype wire

>>> dv/tb_async_hdlc_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_async_hdlc_deframer: self-checking bench for the HDLC receive deframer
// Feeds line bytes (a directed table, then random frames built with a proper
// CRC-16/X.25 FCS and byte stuffing, plus corrupt, aborted and noisy frames)
// through the request stream, predicts every payload byte and frame status in
// a local deframer, and compares each output request in order. Covers the
// size limit at 0, 1, small values, the reset value and the capped maximum.
// ----------------------------------------------------------------------------
module tb_async_hdlc_deframer;
  import adf_pkg::*;

  localparam int unsigned FRAME_CAP   = 4096;
  localparam int unsigned IDLE_PCT    = 6;
  localparam int unsigned SETTLE_CYC  = 8;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned HOLD_AT     = 150;
  localparam int unsigned HOLD_CYC    = 400;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // one line byte; a pinned row carries a hand-written frame end
  typedef struct packed {
    logic [7:0]       rx;
    logic             pinned;
    status_e          st;
    logic [LEN_W-1:0] len;
  } line_item_t;

  // directed rows: padding, good empty frame, CRC errors, double escape,
  // hunt handling, abort of an open frame
  localparam line_item_t DIRECTED [23] = '{
    '{8'h7E, 1'b0, ST_GOOD,  0},  // padding flag
    '{8'h00, 1'b0, ST_GOOD,  0},
    '{8'h00, 1'b0, ST_GOOD,  0},  // FCS of an empty payload
    '{8'h7E, 1'b1, ST_GOOD,  0},
    '{8'h41, 1'b0, ST_GOOD,  0},
    '{8'h7E, 1'b1, ST_CRC,   1},  // one byte never checks
    '{8'h7D, 1'b0, ST_GOOD,  0},
    '{8'h7D, 1'b0, ST_GOOD,  0},  // second escape keeps it pending
    '{8'h5E, 1'b0, ST_GOOD,  0},
    '{8'h7E, 1'b1, ST_CRC,   1},
    '{8'h7D, 1'b0, ST_GOOD,  0},
    '{8'h7E, 1'b0, ST_GOOD,  0},  // abort with nothing open: hunt, silent
    '{8'h11, 1'b0, ST_GOOD,  0},  // ignored in hunt
    '{8'h7D, 1'b0, ST_GOOD,  0},
    '{8'h33, 1'b0, ST_GOOD,  0},  // ignored, escape still pending
    '{8'h7E, 1'b0, ST_GOOD,  0},
    '{8'h7E, 1'b0, ST_GOOD,  0},  // leaves hunt
    '{8'h55, 1'b0, ST_GOOD,  0},
    '{8'hFF, 1'b0, ST_GOOD,  0},
    '{8'h00, 1'b0, ST_GOOD,  0},
    '{8'h7D, 1'b0, ST_GOOD,  0},
    '{8'h7E, 1'b1, ST_ABORT, 3},
    '{8'h7E, 1'b0, ST_GOOD,  0}   // leaves hunt
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_we = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;
  logic             s_valid = 1'b0;
  line_item_t       s_item = '0;
  logic             s_axis_tready;
  logic             m_ready = 1'b0;
  logic             m_axis_tvalid;
  logic [23:0]      m_axis_tdata;
  logic             m_axis_tlast;
  logic             m_axis_tuser;

  logic calm = 1'b0;
  logic rx_hold = 1'b0;

  line_item_t  line_bytes [$];
  result_t     pending_results [$];
  int unsigned queued = 0;
  int unsigned bytes_in = 0;
  int unsigned payload_out = 0;
  int unsigned ends_by_status [5] = '{0, 0, 0, 0, 0};
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // local deframer state
  logic             esc_pend;
  logic             hunt;
  logic             in_frame;
  logic [15:0]      crc_reg;
  logic [LEN_W-1:0] n_stored;
  logic [7:0]       held [2];
  logic [1:0]       n_held;
  logic [LEN_W-1:0] size_cfg;

  async_hdlc_deframer #(.MAX_FRAME(FRAME_CAP)) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_item.rx),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // reflected CRC, one data bit at a time
  function automatic logic [15:0] fcs_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] v;
    v = c;
    for (int k = 0; k < 8; k++) begin
      v = (v[0] ^ b[k]) ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function automatic logic [LEN_W-1:0] size_limit();
    return (size_cfg > FRAME_CAP) ? LEN_W'(FRAME_CAP) : size_cfg;
  endfunction

  function automatic result_t frame_result(status_e st, logic [LEN_W-1:0] n);
    result_t r;
    r = '0;
    r.frame_end = 1'b1;
    r.status = st;
    r.length = n;
    return r;
  endfunction

  task automatic clear_frame();
    in_frame = 1'b0;
    crc_reg = CRC_PRESET;
    n_stored = '0;
    n_held = '0;
    held[0] = '0;
    held[1] = '0;
  endtask

  task automatic reset_rx_state();
    size_cfg = CFG_RESET;
    esc_pend = 1'b0;
    hunt = 1'b0;
    clear_frame();
  endtask

  // one line byte in, at most one output request predicted
  task automatic deframe_byte(input logic [7:0] rx, output bit emit, output result_t res);
    logic [7:0]       b;
    logic [LEN_W-1:0] cnt;
    logic             was_open;
    b = rx;
    emit = 1'b0;
    res = '0;
    if (rx == ESC_BYTE) begin
      esc_pend = 1'b1;
    end else if (rx != FLAG_BYTE) begin
      if (!hunt) begin
        if (esc_pend) begin
          b = rx ^ ESC_XOR;
          esc_pend = 1'b0;
        end
        in_frame = 1'b1;
        if (n_stored >= size_limit()) begin
          // too big: report, then hunt for the next flag
          emit = 1'b1;
          res = frame_result(ST_BIG, n_stored);
          clear_frame();
          esc_pend = 1'b0;
          hunt = 1'b1;
        end else begin
          n_stored = n_stored + 1'b1;
          crc_reg = fcs_step(crc_reg, b);
          if (n_held == 2'd2) begin
            emit = 1'b1;
            res.data_valid = 1'b1;
            res.payload = held[0];
            held[0] = held[1];
            held[1] = b;
          end else begin
            held[n_held[0]] = b;
            n_held = n_held + 1'b1;
          end
        end
      end
    end else if (esc_pend) begin
      // escape then flag: abort
      was_open = in_frame;
      cnt = n_stored;
      hunt = 1'b1;
      esc_pend = 1'b0;
      clear_frame();
      if (was_open) begin
        emit = 1'b1;
        res = frame_result(ST_ABORT, cnt);
      end
    end else if (hunt) begin
      hunt = 1'b0;
    end else if (in_frame) begin
      cnt = n_stored;
      emit = 1'b1;
      if (crc_reg != CRC_GOOD) begin
        res = frame_result(ST_CRC, cnt);
      end else if (cnt < FCS_BYTES) begin
        res = frame_result(ST_RUNT, cnt);
      end else begin
        res = frame_result(ST_GOOD, cnt - FCS_BYTES);
      end
      clear_frame();
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] b);
    line_bytes.push_back('{rx: b, pinned: 1'b0, st: ST_GOOD, len: '0});
    queued++;
  endtask

  // stuff a frame byte; harmless bytes are escaped now and then as well
  task automatic send_escaped(input logic [7:0] b);
    logic [7:0] alt;
    alt = b ^ ESC_XOR;
    if (b == FLAG_BYTE || b == ESC_BYTE ||
        (alt != FLAG_BYTE && alt != ESC_BYTE && $urandom_range(0, 15) == 0)) begin
      if ($urandom_range(0, 9) == 0) send_byte(ESC_BYTE);
      send_byte(ESC_BYTE);
      send_byte(alt);
    end else begin
      send_byte(b);
    end
  endtask

  // payload byte biased towards the framing codes and their stuffed forms
  function automatic logic [7:0] pick_byte();
    logic [7:0] special [4];
    special = '{FLAG_BYTE, ESC_BYTE, FLAG_BYTE ^ ESC_XOR, ESC_BYTE ^ ESC_XOR};
    if ($urandom_range(0, 4) == 0) return special[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed frames; some corrupt, aborted, cut short or noisy
  task automatic queue_random_frame(input int unsigned max_payload);
    logic [7:0]  body [$];
    logic [15:0] c;
    int unsigned plen, kind, cut;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 3) != 0) begin
      plen = $urandom_range(0, (max_payload < 8) ? max_payload : 8);
    end else begin
      plen = $urandom_range(0, max_payload);
    end
    c = CRC_PRESET;
    repeat (plen) begin
      body.push_back(pick_byte());
      c = fcs_step(c, body[$]);
    end
    c = ~c;
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    if (kind >= 70 && kind < 80) begin
      body[$urandom_range(0, body.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
    end
    cut = (kind >= 80 && kind < 95) ? $urandom_range(0, body.size() - 1) : body.size();
    repeat ($urandom_range(1, 2)) send_byte(FLAG_BYTE);
    foreach (body[i]) begin
      if (i < cut) send_escaped(body[i]);
    end
    if (kind >= 80 && kind < 88) begin
      send_byte(ESC_BYTE);
      send_byte(FLAG_BYTE);
    end else if (kind >= 88 && kind < 95) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
    send_byte(FLAG_BYTE);
  endtask

  task automatic queue_random_frames(input int unsigned n_items, input int unsigned max_payload);
    int unsigned mark;
    mark = queued;
    while (queued - mark < n_items) queue_random_frame(max_payload);
  endtask

  task automatic queue_long_frame(input int unsigned n, input bit with_fcs);
    logic [15:0] c;
    logic [7:0]  b;
    c = CRC_PRESET;
    send_byte(FLAG_BYTE);
    repeat (n) begin
      b = pick_byte();
      c = fcs_step(c, b);
      send_escaped(b);
    end
    if (with_fcs) begin
      c = ~c;
      send_escaped(c[7:0]);
      send_escaped(c[15:8]);
    end
    send_byte(FLAG_BYTE);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_cfg = v;
  endtask

  task automatic log_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 100) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // all requests taken, then wait (bounded) for the outstanding results
  task automatic settle();
    int unsigned spin;
    spin = 0;
    while (line_bytes.size() != 0 || s_valid) @(posedge clk);
    while (pending_results.size() != 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk);
      spin++;
    end
    if (pending_results.size() != 0) begin
      log_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));
      pending_results.delete();
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- bus side

  always @(posedge clk) begin : bus_side
    bit      emit;
    result_t res;
    result_t got;
    result_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n) begin
      // input request taken: predict
      if (s_valid && s_axis_tready) begin
        deframe_byte(s_item.rx, emit, res);
        if (s_item.pinned) begin
          emit = 1'b1;
          res = frame_result(s_item.st, s_item.len);
        end
        if (emit) pending_results.push_back(res);
        bytes_in++;
      end

      // output request taken: compare with the oldest expectation
      if (m_axis_tvalid && m_ready) begin
        got.data_valid = m_axis_tuser;
        got.payload = m_axis_tdata[7:0];
        got.frame_end = m_axis_tlast;
        got.status = status_e'(m_axis_tdata[10:8]);
        got.length = m_axis_tdata[23:11];
        if (pending_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result dv=%0b byte=%02h end=%0b st=%0d len=%0d",
                       got.data_valid, got.payload, got.frame_end, got.status, got.length));
        end else begin
          want = pending_results.pop_front();
          if (want.data_valid) payload_out++;
          if (want.frame_end) ends_by_status[int'(want.status)]++;
          if (got.data_valid !== want.data_valid || got.payload !== want.payload ||
              got.frame_end !== want.frame_end || got.status !== want.status ||
              got.length !== want.length) begin
            log_mismatch($sformatf(
              "dv %0b/%0b byte %02h/%02h end %0b/%0b st %0d/%0d len %0d/%0d (got/exp)",
              got.data_valid, want.data_valid, got.payload, want.payload,
              got.frame_end, want.frame_end, got.status, want.status,
              got.length, want.length));
          end
        end
      end

      // next input request, with random gaps
      if (!s_valid || s_axis_tready) begin
        if (line_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          s_valid <= 1'b1;
          s_item <= line_bytes.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end

      m_ready <= !rx_hold && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // long receiver hold-off while bytes keep coming
  initial begin : rx_backpressure
    while (bytes_in < HOLD_AT) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run
    int unsigned lim;
    reset_rx_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset limit: directed table, random frames
    foreach (DIRECTED[i]) begin
      line_bytes.push_back(DIRECTED[i]);
      queued++;
    end
    queue_random_frames(450, 40);
    settle();

    // limit of zero, then one
    write_limit('0);
    queue_random_frames(150, 4);
    settle();
    write_limit(LEN_W'(1));
    queue_random_frames(150, 4);
    settle();

    // small limits; the first with no gaps on either side
    calm <= 1'b1;
    lim = $urandom_range(2, 40);
    write_limit(LEN_W'(lim));
    queue_random_frames(350, lim + 4);
    settle();
    calm <= 1'b0;
    lim = $urandom_range(2, 40);
    write_limit(LEN_W'(lim));
    queue_random_frames(350, lim + 4);
    settle();

    // limit lowered below the count of an open frame
    write_limit('1);
    send_byte(FLAG_BYTE);
    repeat (10) send_escaped(pick_byte());
    settle();
    write_limit(LEN_W'(3));
    send_escaped(pick_byte());
    send_byte(FLAG_BYTE);
    settle();

    // limit above the cap: a long good frame, then random traffic
    write_limit('1);
    queue_long_frame(200, 1'b1);
    queue_random_frames(200, 60);
    settle();

    $display("run covered %0d line bytes, %0d payload bytes out; frame ends", bytes_in,
             payload_out);
    $display("  good %0d, crc %0d, runt %0d, abort %0d, too big %0d; limits 0, 1, small, 4096, 8191",
             ends_by_status[0], ends_by_status[1], ends_by_status[2], ends_by_status[3],
             ends_by_status[4]);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
